### src/tm2d_pkg.sv
// Package for the 2D tape machine: command codes, heading type, stack sizing
// and the instruction pointer step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tm2d_pkg;

    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SIDX_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned TAPE_DEPTH  = 256;

    localparam logic [7:0] CMD_PTR_DEC = 8'h3C; // <
    localparam logic [7:0] CMD_PTR_INC = 8'h3E; // >
    localparam logic [7:0] CMD_INC     = 8'h2B; // +
    localparam logic [7:0] CMD_DEC     = 8'h2D; // -
    localparam logic [7:0] CMD_OUT     = 8'h2E; // .
    localparam logic [7:0] CMD_IN      = 8'h2C; // ,
    localparam logic [7:0] CMD_SKIPZ   = 8'h2F; // /
    localparam logic [7:0] CMD_UP      = 8'h55; // U
    localparam logic [7:0] CMD_DOWN    = 8'h44; // D
    localparam logic [7:0] CMD_LEFT    = 8'h4C; // L
    localparam logic [7:0] CMD_RIGHT   = 8'h52; // R
    localparam logic [7:0] CMD_PUSH    = 8'h56; // V
    localparam logic [7:0] CMD_POP     = 8'h5E; // ^
    localparam logic [7:0] CMD_PEEK    = 8'h21; // !
    localparam logic [7:0] CMD_CLR     = 8'h29; // )
    localparam logic [7:0] CMD_HALT    = 8'h3B; // ;
    localparam logic [7:0] CMD_LOADP   = 8'h7E; // ~
    localparam logic [7:0] CMD_STORE   = 8'h26; // &
    localparam logic [7:0] CMD_JUMP    = 8'h28; // (

    typedef enum logic [1:0] {
        HEAD_RIGHT = 2'd0,
        HEAD_DOWN  = 2'd1,
        HEAD_LEFT  = 2'd2,
        HEAD_UP    = 2'd3
    } heading_t;

    // Returns {y, x} after one cell of travel in heading d.
    function automatic logic [15:0] step_ip(heading_t d, logic [7:0] x, logic [7:0] y);
        logic [15:0] r;
        begin
            r = {y, x};
            case (d)
                HEAD_RIGHT: r = {y, x + 8'd1};
                HEAD_DOWN:  r = {y + 8'd1, x};
                HEAD_LEFT:  r = {y, x - 8'd1};
                HEAD_UP:    r = {y - 8'd1, x};
                default:    r = {y, x};
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### src/tape_machine_2d_instruction_step.sv
// Top level of the 2D tape machine: executes one program character per transfer.
// Uses tm2d_pkg for command codes, heading type and stack sizing.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, cell_present and in_byte, the
//   character under the instruction pointer as fetched outside. The result channel
//   (res_valid/res_ready) returns next_x/next_y/heading for the next fetch, plus
//   the emitted byte, halt flag, command count and stack drop flag.
//   An item passes the input register, the registered tape read and the
//   execute step, which writes back and moves the data pointer, before the
//   result register shows it. The next tape read waits until the current
//   item has executed; after '&' (store coordinates) it also waits for the
//   second write, as the tape has a single write port and '&' writes two cells.
//   An input register takes the next item while the current one executes, and
//   an output register holds a result while the receiver stalls; execution
//   waits only when that output register is still full.
//   Reset clears the tape (through per-cell valid bits, no clearing pass), the
//   pointers, heading, stack level, count and halt flag; stack contents are
//   left undefined. After ';' every item returns the held position, halted = 1.
`timescale 1ns / 1ps
`default_nettype none

module tape_machine_2d_instruction_step (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                func,
    input  logic                      cell_present,
    input  logic [7:0]                in_byte,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic [7:0]                next_x,
    output logic [7:0]                next_y,
    output tm2d_pkg::heading_t        heading,
    output logic                      out_valid,
    output logic [7:0]                out_byte,
    output logic                      halted,
    output logic [31:0]               executed_count,
    output logic                      stack_full_drop
);
    import tm2d_pkg::*;

    // memories
    logic [7:0] tape_mem [TAPE_DEPTH];
    logic [7:0] stk_mem  [STACK_DEPTH];
    logic [TAPE_DEPTH-1:0] tvld_reg;

    // architectural state
    logic [7:0]       dp_reg;
    logic [7:0]       ipx_reg;
    logic [7:0]       ipy_reg;
    heading_t         dir_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic [31:0]      cnt_reg;
    logic             stopped_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_func_reg;
    logic       s1_present_reg;
    logic [7:0] s1_byte_reg;

    // execute stage
    logic       s2_valid_reg;
    logic [7:0] s2_func_reg;
    logic       s2_present_reg;
    logic [7:0] s2_byte_reg;
    logic [7:0] rq0_reg;
    logic [7:0] rq1_reg;
    logic       rvld0_reg;
    logic       rvld1_reg;
    logic [7:0] sq_reg;

    // pending second tape write of '&'
    logic       wr2_pend_reg;
    logic [7:0] wr2_addr_reg;
    logic [7:0] wr2_data_reg;

    // result register
    logic        res_valid_reg;
    logic [7:0]  rx_reg;
    logic [7:0]  ry_reg;
    heading_t    rdir_reg;
    logic        remit_reg;
    logic [7:0]  rbyte_reg;
    logic        rhalt_reg;
    logic [31:0] rcnt_reg;
    logic        rdrop_reg;

    // execute results
    logic [7:0]       dp_next;
    logic [7:0]       ipx_next;
    logic [7:0]       ipy_next;
    heading_t         dir_next;
    logic [LVL_W-1:0] lvl_next;
    logic [31:0]      cnt_next;
    logic             stopped_next;
    logic             emit_c;
    logic             drop_c;
    logic             known_c;
    logic             skip_c;
    logic             twe_c;
    logic [7:0]       twdata_c;
    logic             swe_c;
    logic             wr2_c;
    logic [15:0]      ip_a;
    logic [15:0]      ip_b;
    logic [7:0]       cur_byte;
    logic [7:0]       nxt_byte;

    logic             issue;
    logic             exec;
    logic [7:0]       dp_inc;
    logic [LVL_W-1:0] lvl_dec;
    logic             tw_en;
    logic [7:0]       tw_addr;
    logic [7:0]       tw_data;

    // Reads are issued only when nothing executes and no write is pending,
    // so the tape and stack never need forwarding.
    assign issue    = s1_valid_reg && !s2_valid_reg && !wr2_pend_reg;
    assign exec     = s2_valid_reg && (!res_valid_reg || res_ready);
    assign in_ready = !s1_valid_reg || issue;

    assign dp_inc  = dp_reg + 8'd1;
    assign lvl_dec = lvl_reg - {{(LVL_W-1){1'b0}}, 1'b1};

    assign cur_byte = rvld0_reg ? rq0_reg : 8'h00;
    assign nxt_byte = rvld1_reg ? rq1_reg : 8'h00;

    always_comb
    begin
        dp_next      = dp_reg;
        ipx_next     = ipx_reg;
        ipy_next     = ipy_reg;
        dir_next     = dir_reg;
        lvl_next     = lvl_reg;
        cnt_next     = cnt_reg;
        stopped_next = stopped_reg;
        emit_c       = 1'b0;
        drop_c       = 1'b0;
        known_c      = 1'b1;
        skip_c       = 1'b0;
        twe_c        = 1'b0;
        twdata_c     = 8'h00;
        swe_c        = 1'b0;
        wr2_c        = 1'b0;
        ip_a         = {ipy_reg, ipx_reg};
        ip_b         = {ipy_reg, ipx_reg};
        if (!stopped_reg)
        begin
            if (s2_present_reg)
            begin
                case (s2_func_reg)
                    CMD_PTR_DEC: if (dp_reg != 8'h00) dp_next = dp_reg - 8'd1;
                    CMD_PTR_INC: if (dp_reg != 8'hFF) dp_next = dp_inc;
                    CMD_INC:
                    begin
                        twe_c    = 1'b1;
                        twdata_c = cur_byte + 8'd1;
                    end
                    CMD_DEC:
                    begin
                        twe_c    = 1'b1;
                        twdata_c = cur_byte - 8'd1;
                    end
                    CMD_OUT:     emit_c = 1'b1;
                    CMD_IN:
                    begin
                        twe_c    = 1'b1;
                        twdata_c = s2_byte_reg;
                    end
                    CMD_SKIPZ:   skip_c = (cur_byte == 8'h00);
                    CMD_UP:      dir_next = HEAD_UP;
                    CMD_DOWN:    dir_next = HEAD_DOWN;
                    CMD_LEFT:    dir_next = HEAD_LEFT;
                    CMD_RIGHT:   dir_next = HEAD_RIGHT;
                    CMD_PUSH:
                    begin
                        if (lvl_reg < LVL_W'(STACK_DEPTH))
                        begin
                            swe_c    = 1'b1;
                            lvl_next = lvl_reg + {{(LVL_W-1){1'b0}}, 1'b1};
                        end
                        else
                        begin
                            drop_c = 1'b1;
                        end
                    end
                    CMD_POP:     if (lvl_reg != '0) lvl_next = lvl_dec;
                    CMD_PEEK:
                    begin
                        if (lvl_reg != '0)
                        begin
                            twe_c    = 1'b1;
                            twdata_c = sq_reg;
                        end
                    end
                    CMD_CLR:
                    begin
                        twe_c    = 1'b1;
                        twdata_c = 8'h00;
                    end
                    CMD_HALT:    stopped_next = 1'b1;
                    CMD_LOADP:   dp_next = cur_byte;
                    CMD_STORE:
                    begin
                        twe_c    = 1'b1;
                        twdata_c = ipx_reg;
                        wr2_c    = 1'b1;
                    end
                    CMD_JUMP:
                    begin
                        ipx_next = cur_byte;
                        ipy_next = nxt_byte;
                    end
                    default:     known_c = 1'b0;
                endcase
                if (known_c)
                    cnt_next = cnt_reg + 32'd1;
            end
            ip_a = step_ip(dir_next, ipx_next, ipy_next);
            ip_b = skip_c ? step_ip(dir_next, ip_a[7:0], ip_a[15:8]) : ip_a;
            ipx_next = ip_b[7:0];
            ipy_next = ip_b[15:8];
        end
    end

    // single tape write port, shared by execute and the deferred '&' write
    assign tw_en   = (exec && twe_c) || wr2_pend_reg;
    assign tw_addr = wr2_pend_reg ? wr2_addr_reg : dp_reg;
    assign tw_data = wr2_pend_reg ? wr2_data_reg : twdata_c;

    always_ff @(posedge clk)
    begin
        if (tw_en)
            tape_mem[tw_addr] <= tw_data;
        if (issue)
        begin
            rq0_reg <= tape_mem[dp_reg];
            rq1_reg <= tape_mem[dp_inc];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec && swe_c)
            stk_mem[lvl_reg[SIDX_W-1:0]] <= cur_byte;
        if (issue)
            sq_reg <= stk_mem[lvl_dec[SIDX_W-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvld_reg      <= '0;
            rvld0_reg     <= 1'b0;
            rvld1_reg     <= 1'b0;
            dp_reg        <= 8'h00;
            ipx_reg       <= 8'h00;
            ipy_reg       <= 8'h00;
            dir_reg       <= HEAD_RIGHT;
            lvl_reg       <= '0;
            cnt_reg       <= 32'd0;
            stopped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            wr2_pend_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (tw_en)
                tvld_reg[tw_addr] <= 1'b1;
            if (issue)
            begin
                rvld0_reg <= tvld_reg[dp_reg];
                rvld1_reg <= tvld_reg[dp_inc];
            end

            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (issue)
                s1_valid_reg <= 1'b0;

            if (issue)
                s2_valid_reg <= 1'b1;
            else if (exec)
                s2_valid_reg <= 1'b0;

            wr2_pend_reg <= exec && wr2_c;

            if (exec)
            begin
                dp_reg      <= dp_next;
                ipx_reg     <= ipx_next;
                ipy_reg     <= ipy_next;
                dir_reg     <= dir_next;
                lvl_reg     <= lvl_next;
                cnt_reg     <= cnt_next;
                stopped_reg <= stopped_next;
            end

            if (exec)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_func_reg    <= func;
            s1_present_reg <= cell_present;
            s1_byte_reg    <= in_byte;
        end
        if (issue)
        begin
            s2_func_reg    <= s1_func_reg;
            s2_present_reg <= s1_present_reg;
            s2_byte_reg    <= s1_byte_reg;
        end
        if (exec)
        begin
            wr2_addr_reg <= dp_inc;
            wr2_data_reg <= ipy_reg;
            rx_reg       <= ipx_next;
            ry_reg       <= ipy_next;
            rdir_reg     <= dir_next;
            remit_reg    <= emit_c;
            rbyte_reg    <= emit_c ? cur_byte : 8'h00;
            rhalt_reg    <= stopped_next;
            rcnt_reg     <= cnt_next;
            rdrop_reg    <= drop_c;
        end
    end

    assign res_valid       = res_valid_reg;
    assign next_x          = rx_reg;
    assign next_y          = ry_reg;
    assign heading         = rdir_reg;
    assign out_valid       = remit_reg;
    assign out_byte        = rbyte_reg;
    assign halted          = rhalt_reg;
    assign executed_count  = rcnt_reg;
    assign stack_full_drop = rdrop_reg;

endmodule

`default_nettype wire

### src/tm2d_chk.sv
// Port-level checker for the 2D tape machine, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module tm2d_chk (
    input wire        clk,
    input wire        rst_n,
    input wire        res_valid,
    input wire        res_ready,
    input wire [7:0]  next_x,
    input wire [7:0]  next_y,
    input wire        out_valid,
    input wire [7:0]  out_byte,
    input wire        halted,
    input wire [31:0] executed_count,
    input wire        stack_full_drop
);
    logic        halt_seen_reg;
    logic [31:0] last_cnt_reg;
    logic        res_xfer;

    assign res_xfer = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
            last_cnt_reg  <= 32'd0;
        end
        else if (res_xfer)
        begin
            halt_seen_reg <= halt_seen_reg || halted;
            last_cnt_reg  <= executed_count;
        end
    end

    // once halted, stay halted
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && halt_seen_reg |-> halted)
        else $error("halted dropped after halt");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && halted |-> !out_valid && !stack_full_drop)
        else $error("activity reported while halted");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_byte == 8'h00)
        else $error("out_byte non-zero without output");

    // at most one command is counted per result
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> executed_count == last_cnt_reg
                   || executed_count == last_cnt_reg + 32'd1)
        else $error("executed_count jumped");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(next_x) && $stable(next_y)
                                    && $stable(executed_count))
        else $error("stalled result changed");

endmodule

bind tape_machine_2d_instruction_step tm2d_chk u_tm2d_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .next_x         (next_x),
    .next_y         (next_y),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .halted         (halted),
    .executed_count (executed_count),
    .stack_full_drop(stack_full_drop)
);

`default_nettype wire
